// ===== rtl/core/bmpe_pkg.sv =====
// Package for the binomial mod prime engine: field widths, prime constants,
// build sequencer states and the builder request struct. No dependencies.
package bmpe_pkg;

    localparam int IDX_W = 20;
    localparam int RES_W = 30;

    // Prime modulus and Barrett reciprocal floor(2^60 / PRIME)
    localparam logic [RES_W-1:0] PRIME      = 30'd1000000007;
    localparam logic [30:0]      BARRETT_MU = 31'd1152921496;
    // Fermat exponent PRIME - 2 for the single inversion
    localparam logic [RES_W-1:0] PRIME_EXP  = 30'd1000000005;

    // Cycles from operands to registered result of one modular multiply
    localparam int MUL_LAT = 4;
    localparam int CNT_W   = $clog2(MUL_LAT);

    // Depth of the result queue, which also bounds beats in flight
    localparam int OUT_DEPTH = 16;
    localparam int OUT_PTR_W = $clog2(OUT_DEPTH);

    typedef enum logic [3:0] {
        BLD_FACT0,
        BLD_FACT_MUL,
        BLD_FACT_WAIT,
        BLD_POW_SQR,
        BLD_POW_SQR_WAIT,
        BLD_POW_MUL,
        BLD_POW_MUL_WAIT,
        BLD_INVF_TOP,
        BLD_INVF_MUL,
        BLD_INVF_WAIT,
        BLD_DONE
    } bld_state_t;

    typedef struct packed {
        logic             fact_we;
        logic             invf_we;
        logic [IDX_W-1:0] wr_addr;
        logic [RES_W-1:0] wr_data;
        logic [RES_W-1:0] mul_a;
        logic [RES_W-1:0] mul_b;
        logic             done;
    } bld_req_t;

endpackage

// ===== rtl/core/binomial_mod_prime_engine.sv =====
// Top level of the binomial mod prime engine: query pipeline and result queue.
// Depends on bmpe_pkg, bmpe_ram, bmpe_mulmod and bmpe_builder.
//
// Usage: after reset the block builds its factorial and inverse factorial
// tables and holds s_ready low meanwhile; the build writes one table entry
// per multiply, forward for factorials and backward for inverse factorials,
// plus one inversion by 30 squarings and 15 multiplies, and it issues each
// multiply only once the last one has left the four-stage multiplier.
// Queries then enter on the s_ channel (n, k) and leave on the m_ channel
// (binomial, out_of_range), one beat per cycle unless s_ready or m_ready holds them, in order.
// From an accepted input beat to m_valid the path runs through the stage register,
// the registered table read, two four-stage modular multiplies and the queue.
// Results wait in a 16-entry queue; the input side keeps accepting while
// fewer than 16 beats are in flight, so a stalled receiver only stops input
// once the queue could otherwise overflow. Reset is synchronous, active low,
// and empties the pipeline and queue and restarts the build.
module binomial_mod_prime_engine
    import bmpe_pkg::*;
#(
    parameter int TABLE_SIZE = 524288
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic signed [IDX_W-1:0] s_n_value,
    input  logic signed [IDX_W-1:0] s_k_value,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [RES_W-1:0]        m_binomial,
    output logic                    m_out_of_range
);

    localparam int AW = $clog2(TABLE_SIZE);
    localparam int FLAG_DLY = 2 * MUL_LAT + 1;
    localparam logic signed [IDX_W+1:0] TBL_S = (IDX_W+2)'(TABLE_SIZE);

    bld_req_t bld;

    logic             s_acc;
    logic             m_pop;
    logic [OUT_PTR_W:0] inflight_reg;

    // Stage A
    logic                    a_vld_reg;
    logic signed [IDX_W-1:0] a_n_reg;
    logic signed [IDX_W-1:0] a_k_reg;
    logic [IDX_W-1:0]        a_diff;
    logic                    a_oor;
    logic                    a_zero;

    logic [FLAG_DLY-1:0] vld_dly_reg;
    logic [FLAG_DLY-1:0] oor_dly_reg;
    logic [FLAG_DLY-1:0] zero_dly_reg;
    logic [RES_W-1:0]    fact_dly_reg [MUL_LAT];

    logic [RES_W-1:0] fact_rd;
    logic [RES_W-1:0] invf_rd_a;
    logic [RES_W-1:0] invf_rd_b;
    logic [RES_W-1:0] mm_a_in0;
    logic [RES_W-1:0] mm_a_in1;
    logic [RES_W-1:0] mm_a_y;
    logic [RES_W-1:0] mm_b_y;
    logic [AW-1:0]    ram_wr_addr;

    logic [RES_W:0]     fifo_mem [OUT_DEPTH];
    logic [OUT_PTR_W-1:0] wr_ptr_reg;
    logic [OUT_PTR_W-1:0] rd_ptr_reg;
    logic [OUT_PTR_W:0]   fifo_cnt_reg;
    logic               push;
    logic [RES_W:0]     push_data;

    // Table build sequencer
    bmpe_builder #(
        .TABLE_SIZE (TABLE_SIZE)
    ) u_builder (
        .aclk    (aclk),
        .aresetn (aresetn),
        .mul_y   (mm_a_y),
        .req     (bld)
    );

    assign ram_wr_addr = bld.wr_addr[AW-1:0];

    // Input handshake: accept while built and the queue has room for all in flight
    assign s_ready = bld.done && (inflight_reg < (OUT_PTR_W+1)'(OUT_DEPTH));
    assign s_acc   = s_valid && s_ready;
    assign m_pop   = m_valid && m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inflight_reg <= '0;
        end else begin
            inflight_reg <= inflight_reg + (OUT_PTR_W+1)'(s_acc)
                            - (OUT_PTR_W+1)'(m_pop);
        end
    end

    // Stage A: hold the query
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_vld_reg <= 1'b0;
        end else begin
            a_vld_reg <= s_acc;
        end
    end

    always_ff @(posedge aclk) begin
        a_n_reg <= s_n_value;
        a_k_reg <= s_k_value;
    end

    // Classify the indices
    assign a_diff = a_n_reg - a_k_reg;
    assign a_oor  = $signed({{2{a_n_reg[IDX_W-1]}}, a_n_reg}) >= TBL_S;
    assign a_zero = a_n_reg[IDX_W-1] || a_k_reg[IDX_W-1] || (a_n_reg < a_k_reg);

    // Table memories
    bmpe_ram #(
        .WIDTH (RES_W),
        .DEPTH (TABLE_SIZE)
    ) u_fact_ram (
        .aclk      (aclk),
        .wr_en     (bld.fact_we),
        .wr_addr   (ram_wr_addr),
        .wr_data   (bld.wr_data),
        .rd_addr_a (a_n_reg[AW-1:0]),
        .rd_addr_b (a_n_reg[AW-1:0]),
        .rd_data_a (fact_rd),
        .rd_data_b ()
    );

    bmpe_ram #(
        .WIDTH (RES_W),
        .DEPTH (TABLE_SIZE)
    ) u_invf_ram (
        .aclk      (aclk),
        .wr_en     (bld.invf_we),
        .wr_addr   (ram_wr_addr),
        .wr_data   (bld.wr_data),
        .rd_addr_a (a_k_reg[AW-1:0]),
        .rd_addr_b (a_diff[AW-1:0]),
        .rd_data_a (invf_rd_a),
        .rd_data_b (invf_rd_b)
    );

    // First multiplier serves the build, then the inverse factorial product
    assign mm_a_in0 = bld.done ? invf_rd_a : bld.mul_a;
    assign mm_a_in1 = bld.done ? invf_rd_b : bld.mul_b;

    bmpe_mulmod u_mm_a (
        .aclk (aclk),
        .a    (mm_a_in0),
        .b    (mm_a_in1),
        .y    (mm_a_y)
    );

    // Advance the factorial alongside the first multiply
    always_ff @(posedge aclk) begin
        fact_dly_reg[0] <= fact_rd;
        for (int i = 1; i < MUL_LAT; i++) begin
            fact_dly_reg[i] <= fact_dly_reg[i-1];
        end
    end

    bmpe_mulmod u_mm_b (
        .aclk (aclk),
        .a    (fact_dly_reg[MUL_LAT-1]),
        .b    (mm_a_y),
        .y    (mm_b_y)
    );

    // Advance valid and flags to the multiplier output
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_dly_reg <= '0;
        end else begin
            vld_dly_reg <= {vld_dly_reg[FLAG_DLY-2:0], a_vld_reg};
        end
    end

    always_ff @(posedge aclk) begin
        oor_dly_reg  <= {oor_dly_reg[FLAG_DLY-2:0], a_oor};
        zero_dly_reg <= {zero_dly_reg[FLAG_DLY-2:0], a_zero};
    end

    // Drop the product for flagged queries
    assign push      = vld_dly_reg[FLAG_DLY-1];
    assign push_data = {oor_dly_reg[FLAG_DLY-1],
                        (oor_dly_reg[FLAG_DLY-1] || zero_dly_reg[FLAG_DLY-1])
                            ? '0 : mm_b_y};

    // Result queue
    always_ff @(posedge aclk) begin
        if (push) begin
            fifo_mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            fifo_cnt_reg <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + OUT_PTR_W'(1);
            end
            if (m_pop) begin
                rd_ptr_reg <= rd_ptr_reg + OUT_PTR_W'(1);
            end
            fifo_cnt_reg <= fifo_cnt_reg + (OUT_PTR_W+1)'(push)
                            - (OUT_PTR_W+1)'(m_pop);
        end
    end

    assign m_valid        = (fifo_cnt_reg != '0);
    assign m_binomial     = fifo_mem[rd_ptr_reg][RES_W-1:0];
    assign m_out_of_range = fifo_mem[rd_ptr_reg][RES_W];

endmodule

// ===== rtl/core/bmpe_ram.sv =====
// Generic RAM: one write port, two registered read ports.
// No package dependencies.
module bmpe_ram #(
    parameter int WIDTH = 30,
    parameter int DEPTH = 524288
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
    output logic [WIDTH-1:0]         rd_data_a,
    output logic [WIDTH-1:0]         rd_data_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write, then read both ports into output registers
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_a <= mem[rd_addr_a];
        rd_data_b <= mem[rd_addr_b];
    end

endmodule

// ===== rtl/core/bmpe_mulmod.sv =====
// Four-stage modular multiplier a*b mod PRIME using Barrett reduction.
// Depends on bmpe_pkg.
module bmpe_mulmod
    import bmpe_pkg::*;
(
    input  logic             aclk,
    input  logic [RES_W-1:0] a,
    input  logic [RES_W-1:0] b,
    output logic [RES_W-1:0] y
);

    localparam logic [31:0] P1 = 32'(PRIME);
    localparam logic [31:0] P2 = 32'(PRIME) << 1;

    logic [59:0] prod_reg;
    logic [30:0] q3_reg;
    logic [31:0] xlo_reg;
    logic [31:0] r_reg;
    logic [RES_W-1:0] y_reg;

    logic [61:0] q2;
    logic [61:0] qp;
    logic [31:0] r_fix;

    // Estimate quotient, then form the low word of the remainder
    assign q2 = 62'(prod_reg[59:29]) * 62'(BARRETT_MU);
    assign qp = 62'(q3_reg) * 62'(PRIME);

    // Remainder is below three primes: correct with a single subtract of 2*PRIME or PRIME
    always_comb begin
        if (r_reg >= P2) begin
            r_fix = r_reg - P2;
        end else if (r_reg >= P1) begin
            r_fix = r_reg - P1;
        end else begin
            r_fix = r_reg;
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= 60'(a) * 60'(b);
        q3_reg   <= q2[61:31];
        xlo_reg  <= prod_reg[31:0];
        r_reg    <= xlo_reg - qp[31:0];
        y_reg    <= r_fix[RES_W-1:0];
    end

    assign y = y_reg;

endmodule

// ===== rtl/core/bmpe_builder.sv =====
// Table build sequencer: factorials forward, one Fermat inversion, then
// inverse factorials backward. Depends on bmpe_pkg and a shared multiplier.
module bmpe_builder
    import bmpe_pkg::*;
#(
    parameter int TABLE_SIZE = 524288
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic [RES_W-1:0] mul_y,
    output bld_req_t         req
);

    localparam int AW = $clog2(TABLE_SIZE);
    localparam logic [AW-1:0] LAST_IDX = AW'(TABLE_SIZE - 1);

    bld_state_t state_reg, state_next;
    logic [AW-1:0]    idx_reg;
    logic [4:0]       ebit_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [RES_W-1:0] acc_reg;
    logic [RES_W-1:0] base_reg;
    logic             mul_done;

    assign mul_done = (cnt_reg == CNT_W'(MUL_LAT - 1));

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            BLD_FACT0:     state_next = BLD_FACT_MUL;
            BLD_FACT_MUL:  state_next = BLD_FACT_WAIT;
            BLD_FACT_WAIT: begin
                if (mul_done) begin
                    state_next = (idx_reg == LAST_IDX) ? BLD_POW_SQR : BLD_FACT_MUL;
                end
            end
            BLD_POW_SQR:   state_next = BLD_POW_SQR_WAIT;
            BLD_POW_SQR_WAIT: begin
                if (mul_done) begin
                    if (PRIME_EXP[ebit_reg]) begin
                        state_next = BLD_POW_MUL;
                    end else begin
                        state_next = (ebit_reg == 5'd0) ? BLD_INVF_TOP : BLD_POW_SQR;
                    end
                end
            end
            BLD_POW_MUL:   state_next = BLD_POW_MUL_WAIT;
            BLD_POW_MUL_WAIT: begin
                if (mul_done) begin
                    state_next = (ebit_reg == 5'd0) ? BLD_INVF_TOP : BLD_POW_SQR;
                end
            end
            BLD_INVF_TOP:  state_next = BLD_INVF_MUL;
            BLD_INVF_MUL:  state_next = BLD_INVF_WAIT;
            BLD_INVF_WAIT: begin
                if (mul_done) begin
                    state_next = (idx_reg == AW'(1)) ? BLD_DONE : BLD_INVF_MUL;
                end
            end
            BLD_DONE:      state_next = BLD_DONE;
            default:       state_next = BLD_FACT0;
        endcase
    end

    // Outputs: multiplier operands and table writes
    always_comb begin
        req         = '0;
        req.mul_a   = acc_reg;
        req.mul_b   = acc_reg;
        req.wr_addr = IDX_W'(idx_reg);
        req.wr_data = mul_y;
        case (state_reg)
            BLD_FACT0: begin
                req.fact_we = 1'b1;
                req.wr_addr = '0;
                req.wr_data = RES_W'(1);
            end
            BLD_FACT_MUL:  req.mul_b = RES_W'(idx_reg);
            BLD_FACT_WAIT: req.fact_we = mul_done;
            BLD_POW_MUL:   req.mul_b = base_reg;
            BLD_INVF_TOP: begin
                req.invf_we = 1'b1;
                req.wr_data = acc_reg;
            end
            BLD_INVF_MUL:  req.mul_b = RES_W'(idx_reg);
            BLD_INVF_WAIT: begin
                req.invf_we = mul_done;
                req.wr_addr = IDX_W'(idx_reg - AW'(1));
            end
            BLD_DONE:      req.done = 1'b1;
            default:       req.mul_b = acc_reg;
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= BLD_FACT0;
            idx_reg   <= '0;
            ebit_reg  <= '0;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            case (state_reg)
                BLD_FACT0: idx_reg <= AW'(1);
                BLD_FACT_MUL, BLD_POW_SQR, BLD_POW_MUL, BLD_INVF_MUL: cnt_reg <= '0;
                BLD_FACT_WAIT: begin
                    cnt_reg <= cnt_reg + CNT_W'(1);
                    if (mul_done) begin
                        if (idx_reg == LAST_IDX) begin
                            ebit_reg <= 5'd29;
                        end else begin
                            idx_reg <= idx_reg + AW'(1);
                        end
                    end
                end
                BLD_POW_SQR_WAIT: begin
                    cnt_reg <= cnt_reg + CNT_W'(1);
                    if (mul_done && !PRIME_EXP[ebit_reg] && ebit_reg != 5'd0) begin
                        ebit_reg <= ebit_reg - 5'd1;
                    end
                end
                BLD_POW_MUL_WAIT: begin
                    cnt_reg <= cnt_reg + CNT_W'(1);
                    if (mul_done && ebit_reg != 5'd0) begin
                        ebit_reg <= ebit_reg - 5'd1;
                    end
                end
                BLD_INVF_WAIT: begin
                    cnt_reg <= cnt_reg + CNT_W'(1);
                    if (mul_done) begin
                        idx_reg <= idx_reg - AW'(1);
                    end
                end
                default: cnt_reg <= cnt_reg;
            endcase
        end
    end

    // Running product and inversion base
    always_ff @(posedge aclk) begin
        case (state_reg)
            BLD_FACT0: acc_reg <= RES_W'(1);
            BLD_FACT_WAIT: begin
                if (mul_done) begin
                    if (idx_reg == LAST_IDX) begin
                        base_reg <= mul_y;
                        acc_reg  <= RES_W'(1);
                    end else begin
                        acc_reg <= mul_y;
                    end
                end
            end
            BLD_POW_SQR_WAIT, BLD_POW_MUL_WAIT, BLD_INVF_WAIT: begin
                if (mul_done) begin
                    acc_reg <= mul_y;
                end
            end
            default: acc_reg <= acc_reg;
        endcase
    end

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for binomial_mod_prime_engine: directed table plus random queries.
// Depends on bmpe_pkg and the engine RTL; predicts C(n,k) mod prime from its own tables.
module tb_top;
    import bmpe_pkg::*;

    localparam int  NUM_ENTRIES = 524288;
    localparam longint unsigned MODULUS = 1000000007;
    localparam int  LATENCY     = 11;
    localparam longint CYCLE_LIMIT = 20000000;

    typedef struct {
        logic [RES_W-1:0] binomial;
        logic             out_of_range;
    } binom_result_t;

    typedef struct {
        logic signed [IDX_W-1:0] n;
        logic signed [IDX_W-1:0] k;
        logic                    known;
        logic [RES_W-1:0]        binomial;
    } stim_row_t;

    logic                    aclk = 1'b0;
    logic                    aresetn = 1'b0;
    logic                    s_valid = 1'b0;
    logic                    s_ready;
    logic signed [IDX_W-1:0] s_n_value = '0;
    logic signed [IDX_W-1:0] s_k_value = '0;
    logic                    m_valid;
    logic                    m_ready = 1'b0;
    logic [RES_W-1:0]        m_binomial;
    logic                    m_out_of_range;

    int unsigned   fact_tbl[NUM_ENTRIES];
    int unsigned   inv_tbl[NUM_ENTRIES];
    int unsigned   invfact_tbl[NUM_ENTRIES];
    binom_result_t pending_q[$];
    int            error_count = 0;
    int            send_idle_pct = 0;
    int            recv_stall_pct = 0;
    int            hold_cycles = 0;
    longint        cycle_count = 0;

    binomial_mod_prime_engine i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_n_value      (s_n_value),
        .s_k_value      (s_k_value),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_binomial     (m_binomial),
        .m_out_of_range (m_out_of_range)
    );

    always #5 aclk = ~aclk;

    function automatic int unsigned mod_mul(int unsigned a, int unsigned b);
        longint unsigned prod;
        prod = longint'(a) * longint'(b);
        return int'(prod % MODULUS);
    endfunction

    // Build factorial, inverse and inverse factorial tables
    task automatic build_tables();
        int unsigned r;
        int unsigned q;
        fact_tbl[0] = 1;
        fact_tbl[1] = 1;
        inv_tbl[0] = 0;
        inv_tbl[1] = 1;
        invfact_tbl[0] = 1;
        invfact_tbl[1] = 1;
        for (int i = 2; i < NUM_ENTRIES; i++) begin
            r = 32'(MODULUS % i);
            q = 32'(MODULUS / i);
            fact_tbl[i] = mod_mul(fact_tbl[i-1], i);
            inv_tbl[i] = 32'(MODULUS - mod_mul(inv_tbl[r], q));
            invfact_tbl[i] = mod_mul(invfact_tbl[i-1], inv_tbl[i]);
        end
    endtask

    function automatic binom_result_t predict_binomial(logic signed [IDX_W-1:0] n,
                                                       logic signed [IDX_W-1:0] k);
        binom_result_t res;
        int            ni;
        int            ki;
        ni = n;
        ki = k;
        res.binomial = '0;
        res.out_of_range = 1'b0;
        if (ni >= NUM_ENTRIES) begin
            res.out_of_range = 1'b1;
        end else if (ni >= 0 && ki >= 0 && ni >= ki) begin
            res.binomial = RES_W'(mod_mul(fact_tbl[ni],
                                          mod_mul(invfact_tbl[ki], invfact_tbl[ni-ki])));
        end
        return res;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycle_count);
        error_count++;
    endtask

    // Record accepted queries and check accepted result beats
    always @(posedge aclk) begin
        binom_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_q.size() == 0) begin
                report_mismatch("unexpected beat, binomial", m_binomial, -1);
            end else begin
                want = pending_q.pop_front();
                if (m_binomial !== want.binomial)
                    report_mismatch("binomial", m_binomial, want.binomial);
                if (m_out_of_range !== want.out_of_range)
                    report_mismatch("out_of_range", m_out_of_range, want.out_of_range);
            end
        end
        if (aresetn && s_valid && s_ready)
            pending_q.push_back(predict_binomial(s_n_value, s_k_value));
    end

    // Drive receiver back-pressure, with an optional long hold-off
    always @(posedge aclk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Stop the run at a generous cycle limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    // Offer one beat and hold it until accepted, then idle at random
    task automatic send_query(logic signed [IDX_W-1:0] n, logic signed [IDX_W-1:0] k);
        int gap;
        s_valid <= 1'b1;
        s_n_value <= n;
        s_k_value <= k;
        forever begin
            @(negedge aclk);
            if (s_ready) break;
        end
        @(posedge aclk);
        if ($urandom_range(99) < send_idle_pct) begin
            gap = $urandom_range(1, 4);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic send_random_query();
        int r;
        int n;
        logic signed [IDX_W-1:0] raw_n;
        logic signed [IDX_W-1:0] raw_k;
        r = $urandom_range(99);
        if (r < 70) begin
            n = ($urandom_range(1) == 0) ? $urandom_range(64) : $urandom_range(NUM_ENTRIES - 1);
            send_query(IDX_W'(n), IDX_W'($urandom_range(n)));
        end else if (r < 85) begin
            raw_n = IDX_W'($urandom);
            raw_k = IDX_W'($urandom);
            send_query(raw_n, raw_k);
        end else begin
            n = $urandom_range(1000);
            send_query(IDX_W'(n), IDX_W'(n + 1 + $urandom_range(100)));
        end
    endtask

    // Drop valid, let the last accept register, then wait for every result
    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_q.size() != 0) @(posedge aclk);
        repeat (LATENCY + 4) @(posedge aclk);
    endtask

    stim_row_t directed[] = '{
        '{20'sd0,       20'sd0,       1'b1, 30'd1},
        '{20'sd1,       20'sd0,       1'b1, 30'd1},
        '{20'sd1,       20'sd1,       1'b1, 30'd1},
        '{20'sd5,       20'sd2,       1'b1, 30'd10},
        '{20'sd10,      20'sd3,       1'b1, 30'd120},
        '{20'sd524287,  20'sd0,       1'b1, 30'd1},
        '{20'sd524287,  20'sd524287,  1'b1, 30'd1},
        '{20'sd524287,  20'sd1,       1'b1, 30'd524287},
        '{-20'sd1,      20'sd0,       1'b1, 30'd0},
        '{20'sd0,       -20'sd1,      1'b1, 30'd0},
        '{-20'sd524288, -20'sd524288, 1'b1, 30'd0},
        '{20'sd524287,  -20'sd524288, 1'b1, 30'd0},
        '{20'sd3,       20'sd5,       1'b1, 30'd0},
        '{20'sd524286,  20'sd524287,  1'b1, 30'd0},
        '{20'sd524287,  20'sd262143,  1'b0, 30'd0},
        '{20'sd100000,  20'sd31415,   1'b0, 30'd0},
        '{20'sd40,      20'sd20,      1'b0, 30'd0},
        '{20'sd510000,  20'sd12345,   1'b0, 30'd0}
    };

    initial begin
        build_tables();
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed table: typed-in values must also agree with the predictor
        foreach (directed[i]) begin
            if (directed[i].known &&
                predict_binomial(directed[i].n, directed[i].k).binomial !== directed[i].binomial)
                report_mismatch("directed row", i, directed[i].binomial);
            send_query(directed[i].n, directed[i].k);
        end
        wait_drained();

        // Random phases with different idling on each side
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 65; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 65; end
                default: begin send_idle_pct = 13; recv_stall_pct = 13; end
            endcase
            repeat (150) send_random_query();
            wait_drained();
        end

        // Hold off the receiver so the queue fills and input stalls
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_cycles = 300;
        repeat (40) send_random_query();
        wait_drained();

        if (error_count == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end
endmodule

// ===== sim.f =====
rtl/core/bmpe_pkg.sv
rtl/core/bmpe_ram.sv
rtl/core/bmpe_mulmod.sv
rtl/core/bmpe_builder.sv
rtl/core/binomial_mod_prime_engine.sv
tb/tb_top.sv
